// ----- rtl/core/tcb_pkg.sv -----
package tcb_pkg;

    localparam int ACT_W      = 2;
    localparam int LEVEL_W    = 8;
    localparam int TIME_W     = 64;
    localparam int SLOT_W     = 12;
    localparam int DEPTH_DEF  = 4096;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOG    = 2'd0,
        ACT_LOCATE = 2'd1,
        ACT_COUNT  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_SEEK_A,
        ST_STEP_A,
        ST_SEEK_B,
        ST_STEP_B,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic log_wr;
        logic srch_start;
        logic srch_step;
        logic sel_b;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic any_logged;
        logic step_zero;
        logic is_count;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/core/transition_capture_buffer_top.sv -----
// Transition capture buffer: a ring of DEPTH timestamped level changes.
// Input channel (i_in_valid / o_in_ready) carries one command per beat:
//   log     - store the timestamp in the next slot if the level changed
//   locate  - binary search of the ring for a query time
//   count   - locate start and stop times, return their slot distance
// Output channel (o_out_valid / i_out_ready) returns exactly one beat per
// command, in order.
// A locate or count before any log skips the search.
// The search reads one time-store entry per cycle through a single memory
// read port. One command is in progress at a time, and the next is taken
// the cycle after its result is registered.
// Reset empties the ring at once: a fill count marks unwritten slots, which
// read as time zero, so there is no clearing pass.
// A stalled receiver holds the result in the output register; a following
// command is still accepted and waits for the register to free before
// presenting its result.
module transition_capture_buffer_top #(
    parameter int DEPTH = tcb_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tcb_pkg::ACT_W-1:0]   i_action,
    input  logic [tcb_pkg::LEVEL_W-1:0] i_level,
    input  logic [tcb_pkg::TIME_W-1:0]  i_timestamp,
    input  logic [tcb_pkg::TIME_W-1:0]  i_stop_time,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_logged,
    output logic [tcb_pkg::SLOT_W-1:0]  o_slot_index,
    output logic [tcb_pkg::SLOT_W-1:0]  o_event_count,
    output logic                        o_has_events
);
    import tcb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcb_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_level       (i_level),
        .i_timestamp   (i_timestamp),
        .i_stop_time   (i_stop_time),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_logged      (o_logged),
        .o_slot_index  (o_slot_index),
        .o_event_count (o_event_count),
        .o_has_events  (o_has_events)
    );

endmodule

// ----- rtl/core/tcb_ctrl.sv -----
module tcb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [tcb_pkg::ACT_W-1:0] i_action,
    output logic                  o_in_ready,
    input  tcb_pkg::t_stat        i_stat,
    output tcb_pkg::t_cmd         o_cmd
);
    import tcb_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_action) inside
                        ACT_LOG:    n_state = ST_LOG;
                        ACT_LOCATE,
                        ACT_COUNT:  n_state = i_stat.any_logged ? ST_SEEK_A : ST_EMIT;
                        default:    n_state = ST_EMIT;
                    endcase
                end
            end
            ST_LOG: begin
                o_cmd.log_wr = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_SEEK_A: begin
                o_cmd.srch_start = 1'b1;
                n_state          = ST_STEP_A;
            end
            ST_STEP_A: begin
                o_cmd.srch_step = 1'b1;
                if (i_stat.step_zero) begin
                    n_state = i_stat.is_count ? ST_SEEK_B : ST_EMIT;
                end
            end
            ST_SEEK_B: begin
                o_cmd.srch_start = 1'b1;
                o_cmd.sel_b      = 1'b1;
                n_state          = ST_STEP_B;
            end
            ST_STEP_B: begin
                o_cmd.srch_step = 1'b1;
                o_cmd.sel_b     = 1'b1;
                if (i_stat.step_zero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/tcb_dpath.sv -----
module tcb_dpath #(
    parameter int DEPTH = tcb_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcb_pkg::t_cmd               i_cmd,
    output tcb_pkg::t_stat              o_stat,
    input  logic [tcb_pkg::ACT_W-1:0]   i_action,
    input  logic [tcb_pkg::LEVEL_W-1:0] i_level,
    input  logic [tcb_pkg::TIME_W-1:0]  i_timestamp,
    input  logic [tcb_pkg::TIME_W-1:0]  i_stop_time,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_logged,
    output logic [tcb_pkg::SLOT_W-1:0]  o_slot_index,
    output logic [tcb_pkg::SLOT_W-1:0]  o_event_count,
    output logic                        o_has_events
);
    import tcb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] HALF    = AW'(DEPTH / 2);
    localparam logic [AW-1:0] QUARTER = AW'(DEPTH / 4);
    localparam logic [AW:0]   FULL    = (AW+1)'(DEPTH);

    // time store
    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rdata;
    logic              r_rvalid;
    logic [AW-1:0]     rd_addr;

    // captured item
    logic [ACT_W-1:0]   r_action;
    logic [LEVEL_W-1:0] r_level;
    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  r_stop;

    // ring state
    logic [AW-1:0]      r_newest;
    logic [AW:0]        r_fill;
    logic [LEVEL_W-1:0] r_last_level;
    logic               r_any;

    // search state and results
    logic [AW-1:0] r_probe;
    logic [AW-1:0] r_step;
    logic [AW-1:0] r_slot_a;
    logic [AW-1:0] r_slot_b;
    logic          r_logged;

    logic [TIME_W-1:0] query;
    logic [TIME_W-1:0] eff;
    logic              lt;
    logic              all1;
    logic [AW-1:0]     oldest;
    logic [AW-1:0]     moved;
    logic [AW-1:0]     found;
    logic              step_zero;
    logic              new_level;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     res_slot;
    logic [AW-1:0]     res_count;
    logic [31:0]       slot_wide;
    logic [31:0]       count_wide;
    logic              out_free;

    // compare against the entry read last cycle; unwritten slots read as zero
    assign query     = i_cmd.sel_b ? r_stop : r_time;
    assign eff       = r_rvalid ? r_rdata : '0;
    assign lt        = query < eff;
    assign all1      = &eff;
    assign oldest    = r_newest + 1'b1;
    assign step_zero = (r_step == '0);
    assign moved     = lt ? (r_probe - r_step) : (r_probe + r_step);
    assign found     = (lt && !all1) ? (r_probe - 1'b1) : r_probe;
    assign new_level = (r_level != r_last_level);
    assign wr_addr   = r_newest + 1'b1;

    // pick the next read address
    always_comb begin
        if (i_cmd.srch_start) begin
            rd_addr = oldest + HALF;
        end else if (i_cmd.srch_step && !step_zero) begin
            rd_addr = moved;
        end else begin
            rd_addr = r_probe;
        end
    end

    // write and read the time store
    always_ff @(posedge i_clk) begin
        if (i_cmd.log_wr && new_level) begin
            r_mem[wr_addr] <= r_time;
        end
        r_rdata  <= r_mem[rd_addr];
        r_rvalid <= ({1'b0, rd_addr} < r_fill);
    end

    // hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_level  <= i_level;
            r_time   <= i_timestamp;
            r_stop   <= i_stop_time;
        end
    end

    // ring bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest     <= '1;
            r_fill       <= '0;
            r_last_level <= '0;
            r_any        <= 1'b0;
        end else if (i_cmd.log_wr && new_level) begin
            r_newest     <= wr_addr;
            r_last_level <= r_level;
            r_any        <= 1'b1;
            if (r_fill != FULL) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // advance the binary search
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot_a <= '0;
            r_slot_b <= '0;
            r_logged <= 1'b0;
        end else if (i_cmd.log_wr && new_level) begin
            r_logged <= 1'b1;
        end
        if (i_cmd.srch_start) begin
            r_probe <= rd_addr;
            r_step  <= QUARTER;
        end else if (i_cmd.srch_step) begin
            if (!step_zero) begin
                r_probe <= moved;
                r_step  <= r_step >> 1;
            end else if (i_cmd.sel_b) begin
                r_slot_b <= found;
            end else begin
                r_slot_a <= found;
            end
        end
    end

    // form the result
    assign res_slot   = (r_action == ACT_LOG) ? r_newest : r_slot_a;
    assign res_count  = (r_action == ACT_COUNT) ? (r_slot_b - r_slot_a) : '0;
    assign slot_wide  = 32'(res_slot);
    assign count_wide = 32'(res_count);
    assign out_free   = !o_out_valid || i_out_ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_logged      <= r_logged;
            o_slot_index  <= slot_wide[SLOT_W-1:0];
            o_event_count <= count_wide[SLOT_W-1:0];
            o_has_events  <= r_any;
        end
    end

    assign o_stat.any_logged = r_any;
    assign o_stat.step_zero  = step_zero;
    assign o_stat.is_count   = (r_action == ACT_COUNT);
    assign o_stat.out_free   = out_free;

endmodule

// ----- rtl/core/tcb_checker.sv -----
module tcb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_logged,
    input logic [tcb_pkg::SLOT_W-1:0]  o_slot_index,
    input logic [tcb_pkg::SLOT_W-1:0]  o_event_count,
    input logic                        o_has_events
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_slot_index)
            && $stable(o_event_count) && $stable(o_logged))
        else $error("stalled result changed");

    // one command at a time: an accept drops ready for the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command taken while one in progress");

    // a stored transition means events exist and no distance is reported
    a_logged_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_logged |-> o_has_events && (o_event_count == '0))
        else $error("inconsistent log result");

    // an empty ring reports no distance
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_events |-> (o_event_count == '0))
        else $error("distance reported from empty ring");

endmodule

bind transition_capture_buffer_top tcb_checker u_tcb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_logged      (o_logged),
    .o_slot_index  (o_slot_index),
    .o_event_count (o_event_count),
    .o_has_events  (o_has_events)
);

// ----- tb/transition_capture_buffer_top_test.sv -----
`timescale 1ns / 1ps

module transition_capture_buffer_top_test;

    import tcb_pkg::*;

    localparam int          RING_DEPTH   = DEPTH_DEF;
    localparam int unsigned SLOT_MASK    = RING_DEPTH - 1;
    localparam int          DRAIN_CYCLES = 2 * $clog2(RING_DEPTH) + 10;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          MAX_REPORTS  = 10;

    // action code outside the defined set; the block must answer it inertly
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic              logged;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] count;
        logic              has_events;
    } outcome_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ACT_W-1:0]    i_action;
    logic [LEVEL_W-1:0]  i_level;
    logic [TIME_W-1:0]   i_timestamp;
    logic [TIME_W-1:0]   i_stop_time;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_logged;
    logic [SLOT_W-1:0]   o_slot_index;
    logic [SLOT_W-1:0]   o_event_count;
    logic                o_has_events;

    // shadow copy of the ring
    logic [TIME_W-1:0]   ring_time  [RING_DEPTH];
    logic [LEVEL_W-1:0]  ring_level [RING_DEPTH];
    int unsigned         newest_slot;
    int unsigned         ring_fill;
    bit                  ring_any;

    outcome_t            pending_outcomes[$];
    logic [TIME_W-1:0]   sim_now;

    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  mismatches;
    int                  beats_checked;
    int                  stored_logs;
    int                  locates_sent;
    int                  counts_sent;
    int                  other_sent;
    int unsigned         cycle_count = 0;

    transition_capture_buffer_top #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_level      (i_level),
        .i_timestamp  (i_timestamp),
        .i_stop_time  (i_stop_time),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_logged     (o_logged),
        .o_slot_index (o_slot_index),
        .o_event_count(o_event_count),
        .o_has_events (o_has_events)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // abort a hung run
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_outcomes.size());
        $display("transition_capture_buffer_top_test: FAIL");
        $finish;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    // fixed-depth binary search from the oldest slot
    function automatic int unsigned locate_in_ring(input logic [TIME_W-1:0] t);
        int unsigned step;
        int unsigned probe;
        if (!ring_any)
            return 0;
        step  = RING_DEPTH / 2;
        probe = (((newest_slot + 1) & SLOT_MASK) + step) & SLOT_MASK;
        step  = step >> 1;
        while (step != 0) begin
            if (t < ring_time[probe])
                probe = (probe - step) & SLOT_MASK;
            else
                probe = (probe + step) & SLOT_MASK;
            step = step >> 1;
        end
        // step back one slot unless the entry found is the all-ones time
        if (t < ring_time[probe] && ring_time[probe] != '1)
            probe = (probe - 1) & SLOT_MASK;
        return probe;
    endfunction

    // advance the shadow ring by one command and return its result
    function automatic outcome_t apply_command(input logic [ACT_W-1:0] act,
                                               input logic [LEVEL_W-1:0] lvl,
                                               input logic [TIME_W-1:0] t0,
                                               input logic [TIME_W-1:0] t1);
        outcome_t    res;
        int unsigned from_slot;
        int unsigned to_slot;
        res = '0;
        case (act)
            ACT_LOG: begin
                if (lvl != ring_level[newest_slot]) begin
                    newest_slot             = (newest_slot + 1) & SLOT_MASK;
                    ring_time[newest_slot]  = t0;
                    ring_level[newest_slot] = lvl;
                    ring_any                = 1'b1;
                    if (ring_fill < RING_DEPTH)
                        ring_fill++;
                    res.logged = 1'b1;
                end
                res.slot = SLOT_W'(newest_slot);
            end
            ACT_LOCATE: begin
                res.slot = SLOT_W'(locate_in_ring(t0));
            end
            ACT_COUNT: begin
                from_slot = locate_in_ring(t0);
                to_slot   = locate_in_ring(t1);
                res.slot  = SLOT_W'(from_slot);
                res.count = SLOT_W'((to_slot - from_slot) & SLOT_MASK);
            end
            default: begin
            end
        endcase
        res.has_events = ring_any;
        return res;
    endfunction

    // drive one beat, hold it until accepted, then record the expected result
    task automatic send_command(input logic [ACT_W-1:0] act,
                                input logic [LEVEL_W-1:0] lvl,
                                input logic [TIME_W-1:0] t0,
                                input logic [TIME_W-1:0] t1);
        outcome_t res;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_level     <= lvl;
        i_timestamp <= t0;
        i_stop_time <= t1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        res = apply_command(act, lvl, t0, t1);
        pending_outcomes.push_back(res);
        case (act)
            ACT_LOG:    stored_logs += res.logged;
            ACT_LOCATE: locates_sent++;
            ACT_COUNT:  counts_sent++;
            default:    other_sent++;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected %0h got %0h",
                     cycle_count, what, want, got);
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_results
        outcome_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_checked++;
            if (pending_outcomes.size() == 0) begin
                flag_mismatch("unexpected result beat, slot", '0,
                              TIME_W'(o_slot_index));
            end else begin
                want = pending_outcomes.pop_front();
                if (o_logged !== want.logged)
                    flag_mismatch("logged", TIME_W'(want.logged), TIME_W'(o_logged));
                if (o_slot_index !== want.slot)
                    flag_mismatch("slot_index", TIME_W'(want.slot),
                                  TIME_W'(o_slot_index));
                if (o_event_count !== want.count)
                    flag_mismatch("event_count", TIME_W'(want.count),
                                  TIME_W'(o_event_count));
                if (o_has_events !== want.has_events)
                    flag_mismatch("has_events", TIME_W'(want.has_events),
                                  TIME_W'(o_has_events));
            end
        end
    end

    // receiver stalls at the current rate
    always @(posedge i_clk) begin
        i_out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // pick a query time near a stored entry, at the edges of time, or at random
    function automatic logic [TIME_W-1:0] pick_query_time();
        logic [TIME_W-1:0] anchor;
        if (ring_fill == 0)
            return rand_time();
        anchor = ring_time[(newest_slot - $urandom_range(ring_fill - 1)) & SLOT_MASK];
        case ($urandom_range(9))
            0, 1, 2: return anchor;
            3, 4:    return anchor - 1;
            5:       return anchor + 1;
            6:       return anchor + $urandom_range(40);
            7:       return '0;
            8:       return '1;
            default: return rand_time();
        endcase
    endfunction

    // queries and an unused action before anything is stored, and a first log of level zero
    task automatic test_empty_ring();
        send_command(ACT_LOCATE, 8'h00, '0, '0);
        send_command(ACT_LOCATE, 8'hff, '1, '1);
        send_command(ACT_COUNT, 8'h00, '0, '1);
        send_command(ACT_UNUSED, 8'hff, '1, '1);
        send_command(ACT_LOG, 8'h00, 64'd5, '1);
    endtask

    // store, repeat and all-ones timestamp rules
    task automatic test_log_rules();
        send_command(ACT_LOG, 8'hff, '0, '0);
        send_command(ACT_LOG, 8'hff, 64'd40, '0);
        send_command(ACT_LOG, 8'h5a, 64'd100, '1);
        send_command(ACT_LOG, 8'ha5, 64'd200, '0);
        send_command(ACT_LOG, 8'h00, '1, '0);
        send_command(ACT_UNUSED, 8'h00, '0, '0);
    endtask

    // search around stored times and at both ends of the time range
    task automatic test_search_edges();
        send_command(ACT_LOCATE, 8'h00, '0, '0);
        send_command(ACT_LOCATE, 8'h00, 64'd99, '0);
        send_command(ACT_LOCATE, 8'h00, 64'd100, '0);
        send_command(ACT_LOCATE, 8'h00, 64'd150, '0);
        send_command(ACT_LOCATE, 8'h00, '1, '0);
        send_command(ACT_LOCATE, 8'h00, 64'hffff_ffff_ffff_fffe, '0);
        send_command(ACT_COUNT, 8'h00, '0, '1);
        send_command(ACT_COUNT, 8'h00, '1, '0);
        send_command(ACT_COUNT, 8'h00, 64'd50, 64'd200);
    endtask

    // mostly well-formed logging with queries into it, plus noise
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int                 pick;
        logic [LEVEL_W-1:0] lvl;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sim_now        = rand_time() >> $urandom_range(1, 63);
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                lvl = ($urandom_range(7) == 0) ? ring_level[newest_slot]
                                               : LEVEL_W'($urandom_range(255));
                if ($urandom_range(15) == 0)
                    sim_now += TIME_W'($urandom);
                else
                    sim_now += TIME_W'($urandom_range(1, 50));
                send_command(ACT_LOG, lvl, sim_now, rand_time());
            end else if (pick < 70) begin
                send_command(ACT_LOCATE, LEVEL_W'($urandom), pick_query_time(), rand_time());
            end else if (pick < 92) begin
                send_command(ACT_COUNT, LEVEL_W'($urandom), pick_query_time(),
                             pick_query_time());
            end else begin
                send_command(ACT_W'($urandom_range(3)), LEVEL_W'($urandom),
                             rand_time(), rand_time());
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_action       <= ACT_LOG;
        i_level        <= '0;
        i_timestamp    <= '0;
        i_stop_time    <= '0;
        mismatches     = 0;
        beats_checked  = 0;
        stored_logs    = 0;
        locates_sent   = 0;
        counts_sent    = 0;
        other_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        newest_slot    = SLOT_MASK;
        ring_fill      = 0;
        ring_any       = 1'b0;
        for (int s = 0; s < RING_DEPTH; s++) begin
            ring_time[s]  = '0;
            ring_level[s] = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_ring();
        test_log_rules();
        test_search_edges();
        test_random_traffic(215, 0, 0);
        test_random_traffic(210, 81, 0);
        test_random_traffic(210, 0, 81);
        test_random_traffic(215, 17, 17);
        i_in_valid <= 1'b0;

        // drain outstanding results, then watch for stray beats
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d stored logs, %0d locates, %0d counts, %0d other commands",
                 stored_logs, locates_sent, counts_sent, other_sent);
        $display("checked %0d result beats over four idling mixes, %0d mismatches",
                 beats_checked, mismatches);
        if (mismatches == 0)
            $display("transition_capture_buffer_top_test: PASS");
        else
            $display("transition_capture_buffer_top_test: FAIL");
        $finish;
    end

endmodule
